/* rtl/rvc_pkg.sv */
// shared types and constants for the running velocity covariance block
// no dependencies
package rvc_pkg;

    localparam int DEF_CELLS = 4096;
    localparam int CELL_W    = 12;
    localparam int VEL_W     = 32;
    localparam int STR_W     = 48;
    localparam int FRAC_W    = 16;
    // dividend magnitude bits of the floor divider
    localparam int DIV_W     = 50;
    // abs stage, one stage per quotient bit, sign fixup stage
    localparam int DIV_LAT   = DIV_W + 2;
    localparam int IN_W      = 112;
    localparam int OUT_W     = 400;
    localparam int NCOMP     = 6;

    localparam logic signed [STR_W-1:0] STR_MAX = {1'b0, {(STR_W-1){1'b1}}};
    localparam logic signed [STR_W-1:0] STR_MIN = {1'b1, {(STR_W-1){1'b0}}};

    typedef logic signed [VEL_W-1:0] vel_t;
    typedef vel_t [2:0] vec3_t;
    typedef logic signed [STR_W-1:0] str_t;
    typedef str_t [NCOMP-1:0] str6_t;
    typedef logic signed [DIV_W:0] dvd_t;

    // component order xx xy xz yy yz zz, as pairs of vector indexes
    localparam int COMP_A [NCOMP] = '{0, 0, 0, 1, 1, 2};
    localparam int COMP_B [NCOMP] = '{0, 1, 2, 1, 2, 2};

endpackage

/* rtl/rvc_store.sv */
// state memory with one write port and one registered read port
// no dependencies
module rvc_store #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* rtl/rvc_div.sv */
// pipelined floor divider, signed dividend by positive 32 bit divisor
// one quotient bit per stage; depends on rvc_pkg
module rvc_div (
    input  logic               clk,
    input  logic               en,
    input  rvc_pkg::dvd_t      dividend,
    input  logic [31:0]        divisor,
    output rvc_pkg::dvd_t      quotient
);
    import rvc_pkg::*;

    logic              neg_reg [DIV_W+1];
    logic [31:0]       n_reg   [DIV_W+1];
    logic [31:0]       rem_reg [DIV_W+1];
    logic [DIV_W-1:0]  dq_reg  [DIV_W+1];
    logic [31:0]       rem_next [DIV_W+1];
    logic [DIV_W-1:0]  dq_next  [DIV_W+1];
    logic [32:0]       trial    [DIV_W+1];
    logic              ge       [DIV_W+1];
    dvd_t              mag;
    dvd_t              res;

    assign mag = dividend[DIV_W] ? -dividend : dividend;

    always_comb
    begin
        rem_next[0] = '0;
        dq_next[0]  = mag[DIV_W-1:0];
        trial[0]    = '0;
        ge[0]       = 1'b0;
        for (int k = 1; k <= DIV_W; k++)
        begin
            trial[k]    = {rem_reg[k-1], dq_reg[k-1][DIV_W-1]};
            ge[k]       = trial[k] >= {1'b0, n_reg[k-1]};
            rem_next[k] = ge[k] ? 32'(trial[k] - {1'b0, n_reg[k-1]}) : trial[k][31:0];
            dq_next[k]  = {dq_reg[k-1][DIV_W-2:0], ge[k]};
        end
    end

    // sign fixup gives floor rounding
    always_comb
    begin
        if (neg_reg[DIV_W])
        begin
            res = -$signed({1'b0, dq_reg[DIV_W]})
                  - dvd_t'(rem_reg[DIV_W] != '0);
        end
        else
        begin
            res = $signed({1'b0, dq_reg[DIV_W]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg[0] <= dividend[DIV_W];
            n_reg[0]   <= divisor;
            rem_reg[0] <= rem_next[0];
            dq_reg[0]  <= dq_next[0];
            for (int k = 1; k <= DIV_W; k++)
            begin
                neg_reg[k] <= neg_reg[k-1];
                n_reg[k]   <= n_reg[k-1];
                rem_reg[k] <= rem_next[k];
                dq_reg[k]  <= dq_next[k];
            end
            quotient <= res;
        end
    end

endmodule

/* rtl/running_velocity_covariance.sv */
// running mean and reynolds stress per mesh cell; uses rvc_pkg, rvc_store, rvc_div
// throughput one item per cycle while the pipeline is not stalled and no clearing pass runs,
//   a sample for a cell still in flight waits until that cell has been written back
// pipeline stalls as a whole while the output register holds an untaken result
// reset: step count to 1, pipeline empty, then a clearing pass over all CELLS addresses
//   zeroes both memories before the first input transfer is taken
module running_velocity_covariance #(
    parameter int CELLS = rvc_pkg::DEF_CELLS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // cell_index[11:0], velocity_x[43:12], velocity_y[75:44], velocity_z[107:76]
    input  logic [rvc_pkg::IN_W-1:0]  s_axis_tdata,
    input  logic                      s_axis_tlast,   // last_cell
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // out_cell[11:0], mean_out_x/y/z[43:12][75:44][107:76],
    // stress_xx[155:108], xy[203:156], xz[251:204], yy[299:252], yz[347:300],
    // zz[395:348], zero fill above
    output logic [rvc_pkg::OUT_W-1:0] m_axis_tdata
);
    import rvc_pkg::*;

    localparam int AW   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MW   = 3 * VEL_W;
    localparam int SW   = NCOMP * STR_W;
    localparam int NPIPE = DIV_LAT + 5;

    typedef logic signed [STR_W:0] s1_t;
    typedef logic signed [STR_W+3:0] t_t;

    typedef struct packed {
        logic [AW-1:0]     addr;
        logic [CELL_W-1:0] cidx;
        vec3_t             m;
        s1_t [NCOMP-1:0]   s1;
    } side_t;

    // global advance: the pipeline moves when the output slot is free or taken
    logic en;
    logic acc;
    logic hazard;
    logic [AW-1:0] in_addr;
    logic [CELL_W-1:0] in_cell;

    // clearing pass
    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [31:0]   step_reg, step_next;

    // stage 0: memory read in flight
    logic              v0_reg;
    logic [AW-1:0]     a0_reg;
    logic [CELL_W-1:0] c0_reg;
    vec3_t             u0_reg;
    logic [31:0]       n0_reg;
    logic [MW-1:0]     m_rd;
    logic [SW-1:0]     s_rd;
    vec3_t             m_old;
    str6_t             s_old;

    // stage 1: products of old mean and of sample
    logic              v1_reg;
    logic [AW-1:0]     a1_reg;
    logic [CELL_W-1:0] c1_reg;
    logic [31:0]       n1_reg;
    vec3_t             m1_reg;
    str6_t             s1s_reg;
    str6_t             mmq1_reg;
    str6_t             uuq1_reg;
    logic signed [VEL_W:0] dm1_reg [3];
    logic signed [2*VEL_W-1:0] pmm [NCOMP];
    logic signed [2*VEL_W-1:0] puu [NCOMP];

    // stage 2: dividends
    logic              v2_reg;
    logic [31:0]       n2_reg;
    side_t             side2_reg;
    dvd_t              dv2_reg [3+NCOMP];
    s1_t               s1c [NCOMP];

    // divider and its side line
    dvd_t              q_div [3+NCOMP];
    logic              vs_reg [DIV_LAT];
    side_t             side_reg [DIV_LAT];

    // stage e: new mean, partial stress
    logic              ve_reg;
    logic [AW-1:0]     ae_reg;
    logic [CELL_W-1:0] ce_reg;
    vec3_t             nm_e_reg;
    t_t                te_reg [NCOMP];

    // stage f: products of new mean
    logic              vf_reg;
    logic [AW-1:0]     af_reg;
    logic [CELL_W-1:0] cf_reg;
    vec3_t             nm_f_reg;
    t_t                tf_reg [NCOMP];
    str6_t             nnq_f_reg;
    logic signed [2*VEL_W-1:0] pnn [NCOMP];

    // result
    str6_t             s_new;
    logic signed [STR_W+4:0] r_wide [NCOMP];
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    // write port
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [MW-1:0]     wr_mean;
    logic [SW-1:0]     wr_str;

    // in-flight tracking for the read-after-write interlock
    logic              pv [NPIPE];
    logic [AW-1:0]     pa [NPIPE];

    assign in_cell = s_axis_tdata[CELL_W-1:0];

    // store address is the cell index modulo CELLS
    generate
        if (CELLS >= (1 << CELL_W))
        begin : g_addr_wide
            assign in_addr = AW'(in_cell);
        end
        else
        begin : g_addr_mod
            localparam logic [24:0] RECIP = 25'(((64'd1 << 24) + CELLS - 1) / CELLS);
            logic [36:0] idx_prod;
            logic [12:0] idx_q;
            logic [32:0] qc;
            logic [12:0] idx_r;
            assign idx_prod = 37'(in_cell) * 37'(RECIP);
            assign idx_q    = idx_prod[36:24];
            assign qc       = 33'(idx_q) * 33'(CELLS);
            assign idx_r    = 13'(in_cell) - qc[12:0];
            assign in_addr  = AW'(idx_r);
        end
    endgenerate

    always_comb
    begin
        pv[0] = v0_reg; pa[0] = a0_reg;
        pv[1] = v1_reg; pa[1] = a1_reg;
        pv[2] = v2_reg; pa[2] = side2_reg.addr;
        for (int k = 0; k < DIV_LAT; k++)
        begin
            pv[3+k] = vs_reg[k];
            pa[3+k] = side_reg[k].addr;
        end
        pv[DIV_LAT+3] = ve_reg; pa[DIV_LAT+3] = ae_reg;
        pv[DIV_LAT+4] = vf_reg; pa[DIV_LAT+4] = af_reg;
        hazard = 1'b0;
        for (int k = 0; k < NPIPE; k++)
        begin
            hazard = hazard | (pv[k] && (pa[k] == in_addr));
        end
    end

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en && !clr_active_reg && !hazard;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == AW'(CELLS - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
        step_next = step_reg;
        if (acc && s_axis_tlast && (step_reg != '1))
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // memories: mean vector and six stress components
    assign wr_en   = clr_active_reg || (en && vf_reg);
    assign wr_addr = clr_active_reg ? clr_addr_reg : af_reg;
    assign wr_mean = clr_active_reg ? '0 : MW'(nm_f_reg);
    assign wr_str  = clr_active_reg ? '0 : SW'(s_new);

    rvc_store #(.WIDTH(MW), .DEPTH(CELLS), .AW(AW)) u_mean_store (
        .clk     (clk),
        .rd_en   (en),
        .rd_addr (in_addr),
        .rd_data (m_rd),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_mean)
    );

    rvc_store #(.WIDTH(SW), .DEPTH(CELLS), .AW(AW)) u_stress_store (
        .clk     (clk),
        .rd_en   (en),
        .rd_addr (in_addr),
        .rd_data (s_rd),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_str)
    );

    assign m_old = vec3_t'(m_rd);
    assign s_old = str6_t'(s_rd);

    // stage 1 and stage f products, floored to q32.16 by dropping 16 low bits; stage 2 sums
    always_comb
    begin
        for (int k = 0; k < NCOMP; k++)
        begin
            pmm[k] = 64'(m_old[COMP_A[k]]) * 64'(m_old[COMP_B[k]]);
            puu[k] = 64'(u0_reg[COMP_A[k]]) * 64'(u0_reg[COMP_B[k]]);
            pnn[k] = 64'(nm_e_reg[COMP_A[k]]) * 64'(nm_e_reg[COMP_B[k]]);
            s1c[k] = s1_t'(s1s_reg[k]) + s1_t'(mmq1_reg[k]);
        end
    end

    // final stress with saturation
    always_comb
    begin
        for (int k = 0; k < NCOMP; k++)
        begin
            r_wide[k] = (STR_W+5)'(tf_reg[k]) - (STR_W+5)'(nnq_f_reg[k]);
            if (r_wide[k] > (STR_W+5)'(STR_MAX))
            begin
                s_new[k] = STR_MAX;
            end
            else if (r_wide[k] < (STR_W+5)'(STR_MIN))
            begin
                s_new[k] = STR_MIN;
            end
            else
            begin
                s_new[k] = r_wide[k][STR_W-1:0];
            end
        end
    end

    generate
        for (genvar g = 0; g < 3 + NCOMP; g++)
        begin : g_div
            rvc_div u_div (
                .clk      (clk),
                .en       (en),
                .dividend (dv2_reg[g]),
                .divisor  (n2_reg),
                .quotient (q_div[g])
            );
        end
    endgenerate

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            step_reg       <= 32'd1;
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            for (int k = 0; k < DIV_LAT; k++)
            begin
                vs_reg[k] <= 1'b0;
            end
            ve_reg         <= 1'b0;
            vf_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            step_reg       <= step_next;
            if (en)
            begin
                v0_reg    <= acc;
                v1_reg    <= v0_reg;
                v2_reg    <= v1_reg;
                vs_reg[0] <= v2_reg;
                for (int k = 1; k < DIV_LAT; k++)
                begin
                    vs_reg[k] <= vs_reg[k-1];
                end
                ve_reg        <= vs_reg[DIV_LAT-1];
                vf_reg        <= ve_reg;
                out_valid_reg <= vf_reg;
            end
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a0_reg <= in_addr;
            c0_reg <= in_cell;
            u0_reg <= vec3_t'(s_axis_tdata[CELL_W +: MW]);
            n0_reg <= step_reg;

            a1_reg   <= a0_reg;
            c1_reg   <= c0_reg;
            n1_reg   <= n0_reg;
            m1_reg   <= m_old;
            s1s_reg  <= s_old;
            for (int k = 0; k < NCOMP; k++)
            begin
                mmq1_reg[k] <= pmm[k][2*VEL_W-1:FRAC_W];
                uuq1_reg[k] <= puu[k][2*VEL_W-1:FRAC_W];
            end
            for (int i = 0; i < 3; i++)
            begin
                dm1_reg[i] <= (VEL_W+1)'(u0_reg[i]) - (VEL_W+1)'(m_old[i]);
            end

            n2_reg         <= n1_reg;
            side2_reg.addr <= a1_reg;
            side2_reg.cidx <= c1_reg;
            side2_reg.m    <= m1_reg;
            for (int i = 0; i < 3; i++)
            begin
                dv2_reg[i] <= (DIV_W+1)'(dm1_reg[i]);
            end
            for (int k = 0; k < NCOMP; k++)
            begin
                side2_reg.s1[k] <= s1c[k];
                dv2_reg[3+k]    <= (DIV_W+1)'(uuq1_reg[k]) - (DIV_W+1)'(s1c[k]);
            end

            side_reg[0] <= side2_reg;
            for (int k = 1; k < DIV_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            ae_reg <= side_reg[DIV_LAT-1].addr;
            ce_reg <= side_reg[DIV_LAT-1].cidx;
            for (int i = 0; i < 3; i++)
            begin
                nm_e_reg[i] <= side_reg[DIV_LAT-1].m[i] + q_div[i][VEL_W-1:0];
            end
            for (int k = 0; k < NCOMP; k++)
            begin
                te_reg[k] <= (STR_W+4)'(side_reg[DIV_LAT-1].s1[k])
                             + (STR_W+4)'(q_div[3+k]);
            end

            af_reg   <= ae_reg;
            cf_reg   <= ce_reg;
            nm_f_reg <= nm_e_reg;
            for (int k = 0; k < NCOMP; k++)
            begin
                tf_reg[k]    <= te_reg[k];
                nnq_f_reg[k] <= pnn[k][2*VEL_W-1:FRAC_W];
            end

            out_data_reg <= {4'b0, SW'(s_new), MW'(nm_f_reg), cf_reg};
        end
    end

endmodule

/* tb/tb_running_velocity_covariance.sv */
// testbench for running_velocity_covariance: directed and random velocity samples
// checked against an in-bench model of the running mean and stress update
// depends on rvc_pkg and the running_velocity_covariance rtl
module tb_running_velocity_covariance;
    import rvc_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata;   // cell_index, velocity_x, velocity_y, velocity_z
    logic                s_axis_tlast;   // last_cell
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_W-1:0]    m_axis_tdata;   // out_cell, mean x/y/z, stress xx xy xz yy yz zz

    // one expected result, packed as on m_axis_tdata (cell index in the low bits)
    typedef struct packed {
        str6_t             stress;
        vec3_t             mean;
        logic [CELL_W-1:0] cell_idx;
    } stat_t;

    // model state
    longint unsigned step_n;
    vec3_t           mean_mem [DEF_CELLS];
    str6_t           stress_mem [DEF_CELLS];

    stat_t expected_stats [$];
    int    mismatches;
    int    hold_off;       // long receiver stall, in cycles
    bit    calm;           // no idling in the last part of the run
    bit    in_idle_on;     // sender idling enabled

    running_velocity_covariance u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // floor division by a positive divisor
    function automatic longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // q16.16 times q16.16 to q32.16, floor
    function automatic longint qprod(vel_t a, vel_t b);
        longint p;
        p = longint'(a) * longint'(b);
        return p >>> FRAC_W;
    endfunction

    function automatic str_t clip48(longint v);
        if (v > longint'(STR_MAX))
            return STR_MAX;
        if (v < longint'(STR_MIN))
            return STR_MIN;
        return str_t'(v);
    endfunction

    // apply one sample to the model and return the expected result
    function automatic stat_t update_cell(logic [CELL_W-1:0] cell_idx, vec3_t u, bit last);
        stat_t  r;
        vec3_t  m;
        vec3_t  nm;
        longint n;
        longint s1;
        longint v;
        int     idx;
        idx = int'(cell_idx) % DEF_CELLS;
        n = (step_n == 0) ? 1 : longint'(step_n);
        m = mean_mem[idx];
        for (int i = 0; i < 3; i++)
            nm[i] = vel_t'(longint'(m[i]) + floor_div(longint'(u[i]) - longint'(m[i]), n));
        for (int c = 0; c < NCOMP; c++)
        begin
            s1 = longint'(stress_mem[idx][c]) + qprod(m[COMP_A[c]], m[COMP_B[c]]);
            v = s1 + floor_div(qprod(u[COMP_A[c]], u[COMP_B[c]]) - s1, n)
                - qprod(nm[COMP_A[c]], nm[COMP_B[c]]);
            r.stress[c] = clip48(v);
        end
        mean_mem[idx] = nm;
        stress_mem[idx] = r.stress;
        if (last && step_n != 64'hFFFF_FFFF)
            step_n = step_n + 1;
        r.cell_idx = cell_idx;
        r.mean = nm;
        return r;
    endfunction

    // send one sample, wait for its transfer
    task automatic send_sample(logic [CELL_W-1:0] cell_idx, vec3_t u, bit last);
        int gap;
        if (in_idle_on && !calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, u[2], u[1], u[0], cell_idx};
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_stats.push_back(update_cell(cell_idx, u, last));
    endtask

    task automatic drop_valid();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (expected_stats.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    function automatic vel_t rand_vel();
        case ($urandom_range(0, 5))
            0: return vel_t'($urandom);
            1: return vel_t'(32'h7FFF_FFFF);
            2: return vel_t'(32'h8000_0000);
            default: return vel_t'($urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000);
        endcase
    endfunction

    function automatic vec3_t rand_vec();
        vec3_t u;
        for (int i = 0; i < 3; i++)
            u[i] = rand_vel();
        return u;
    endfunction

    // extremes of the fields, stress saturation, first and later steps
    task automatic test_directed();
        vec3_t u;
        u = '{vel_t'(32'h7FFF_FFFF), vel_t'(32'h7FFF_FFFF), vel_t'(32'h7FFF_FFFF)};
        send_sample(12'd0, u, 1'b0);
        u = '{vel_t'(32'h8000_0000), vel_t'(32'h8000_0000), vel_t'(32'h8000_0000)};
        send_sample(12'd4095, u, 1'b0);
        u = '{vel_t'(32'h8000_0000), vel_t'(32'h7FFF_FFFF), vel_t'(0)};
        send_sample(12'd1, u, 1'b0);
        u = '{vel_t'(-1), vel_t'(1), vel_t'(32'h0001_0000)};
        send_sample(12'd2, u, 1'b0);
        u = '{vel_t'(0), vel_t'(0), vel_t'(0)};
        send_sample(12'd3, u, 1'b1);
        // step two on cells 0, 4095 and 2, including back to back on one cell, then step three on two new cells
        u = '{vel_t'(32'h8000_0000), vel_t'(32'h8000_0000), vel_t'(32'h8000_0000)};
        send_sample(12'd0, u, 1'b0);
        u = '{vel_t'(32'h7FFF_FFFF), vel_t'(32'h7FFF_FFFF), vel_t'(32'h7FFF_FFFF)};
        send_sample(12'd4095, u, 1'b0);
        send_sample(12'd4095, u, 1'b0);
        u = '{vel_t'(32'hFFFF_8000), vel_t'(32'h0000_8001), vel_t'(32'hAAAA_5555)};
        send_sample(12'd2, u, 1'b1);
        u = '{vel_t'(32'h5555_AAAA), vel_t'(32'hAAAA_5555), vel_t'(32'h0F0F_F0F0)};
        send_sample(12'hAAA, u, 1'b0);
        send_sample(12'h555, u, 1'b1);
        drop_valid();
    endtask

    // whole time steps over a small cell range, with some noise items
    task automatic test_random_steps(int items, int span);
        int   done;
        int   base;
        int   cnt;
        done = 0;
        while (done < items)
        begin
            base = $urandom_range(0, DEF_CELLS - span);
            cnt = $urandom_range(1, span);
            for (int i = 0; i < cnt && done < items; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_sample(12'($urandom), rand_vec(), $urandom_range(0, 9) == 0);
                else
                    send_sample(12'(base + i), rand_vec(), i == cnt - 1);
                done++;
            end
        end
        drop_valid();
    endtask

    // receiver holds off while the sender keeps offering, then sender waits for drain
    task automatic test_backpressure();
        hold_off = 400;
        for (int i = 0; i < 120; i++)
            send_sample(12'($urandom_range(0, 15)), rand_vec(), i % 16 == 15);
        drop_valid();
        wait_drained();
        for (int i = 0; i < 30; i++)
            send_sample(12'($urandom_range(0, 3)), rand_vec(), i % 4 == 3);
        drop_valid();
    endtask

    // receiver side: random stall bursts, or a long hold-off on request
    initial
    begin : rx_ready
        int n;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                m_axis_tready <= 1'b0;
                n = hold_off;
                hold_off = 0;
                repeat (n) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        stat_t got;
        stat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = stat_t'(m_axis_tdata[$bits(stat_t)-1:0]);
            if (expected_stats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %h", got);
            end
            else
            begin
                want = expected_stats.pop_front();
                if (got !== want || m_axis_tdata[OUT_W-1:$bits(stat_t)] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch cell exp %0d got %0d", want.cell_idx,
                                 got.cell_idx);
                        for (int i = 0; i < 3; i++)
                            $display("  mean[%0d] exp %0d got %0d", i, want.mean[i],
                                     got.mean[i]);
                        for (int c = 0; c < NCOMP; c++)
                            $display("  stress[%0d] exp %0d got %0d", c, want.stress[c],
                                     got.stress[c]);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        #30000000;
        $display("tb_running_velocity_covariance NOT OK");
        $finish;
    end

    initial
    begin : main
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        mismatches = 0;
        hold_off = 0;
        calm = 1'b0;
        in_idle_on = 1'b1;
        step_n = 1;
        for (int i = 0; i < DEF_CELLS; i++)
        begin
            mean_mem[i] = '0;
            stress_mem[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_steps(1200, 8);
        calm = 1'b1;
        test_random_steps(400, 6);

        wait_drained();
        repeat (DIV_LAT + 20) @(posedge clk);
        if (mismatches == 0 && expected_stats.size() == 0)
            $display("tb_running_velocity_covariance OK");
        else
            $display("tb_running_velocity_covariance NOT OK");
        $finish;
    end
endmodule
